>>> hdl/pss_pkg.sv
package pss_pkg;

    localparam int MAX_RING = 1024;
    localparam int RING_AW  = $clog2(MAX_RING);
    localparam int FILL_W   = RING_AW + 1;
    localparam int LEN_W    = 11;
    localparam int GAIN_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEN_W-1:0]  RING_LENGTH_RESET = LEN_W'(100);
    localparam logic [GAIN_W-1:0] DECAY_GAIN_RESET  = GAIN_W'(65274);
    localparam logic [LEN_W-1:0]  RING_LENGTH_MIN   = LEN_W'(2);
    localparam logic [LEN_W-1:0]  RING_LENGTH_MAX   = LEN_W'(MAX_RING);

    localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_GAIN  = CFG_IDX_W'(1);

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_FULL = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef struct packed {
        logic                       command;
        logic signed [SAMPLE_W-1:0] load_value;
        logic                       restart;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] current_sample;
        logic [1:0]                 status;
        logic                       ring_full;
        logic [COUNT_W-1:0]         tick_count;
    } t_out_item;

endpackage

>>> hdl/plucked_string_synth.sv
// plucked string synthesizer (karplus-strong ring of signed 16-bit samples)
// input channel: i_in_valid / o_in_stall carry one item (tick or load); an item
// is taken at a clock edge with valid high and stall low
// output channel: o_out_valid / i_out_stall return one result item per input item,
// in order; a stalled result holds until taken
// config channel: i_cfg_valid / o_cfg_ready with register index and data,
// index 0 ring_length, 1 decay_gain; other indexes are ignored; ready is always high
// a result passes stages 1, 2 and 3 and then enters the output queue;
// the input takes new items before earlier results have left, until the credit count
// stops at 4; a tick whose second sample is still being written back by an earlier
// item waits until that write is done (as with a ring length of 2)
// the ring memory has one read and one write port; every tick or load that succeeds
// writes back in the last pipeline stage, ticks read the next sample when taken
// a 4-entry output queue and an item credit count let the pipeline keep going
// when the receiver stalls; once 4 items are outstanding the input stalls
// reset: ring empty, head 0, tick count 0, registers back to their defaults;
// ring contents are left as they are, no clearing pass
module plucked_string_synth
    import pss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;

    typedef struct packed {
        logic                       valid;
        logic                       tick_ok;
        logic                       load_ok;
        logic                       load_empty;
        logic                       fill_nz;
        logic signed [SAMPLE_W-1:0] load_value;
        logic [RING_AW-1:0]         wr_addr;
        logic [1:0]                 status;
        logic                       ring_full;
        logic [COUNT_W-1:0]         tick_count;
    } t_s1;

    typedef struct packed {
        logic                       valid;
        logic                       tick_ok;
        logic                       wr_en;
        logic [RING_AW-1:0]         wr_addr;
        logic signed [SAMPLE_W-1:0] load_value;
        t_out_item                  result;
    } t_s2;

    // configuration
    logic [LEN_W-1:0]  r_ring_length;
    logic [GAIN_W-1:0] r_decay_gain;

    // ring control
    logic [RING_AW-1:0] r_head;
    logic [FILL_W-1:0]  r_fill;
    logic [COUNT_W-1:0] r_ticks;
    logic [PEND_W-1:0]  r_pending;

    // ring memory
    logic signed [SAMPLE_W-1:0] r_ring [MAX_RING];
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic signed [SAMPLE_W-1:0] r_front;

    // pipeline
    t_s1 r_s1;
    t_s2 r_s2;
    t_s2 r_s3;
    logic signed [SAMPLE_W-1:0] r_s2_avg;
    logic signed [PROD_W-1:0]   r_s3_prod;

    // output queue
    t_out_item          r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [PEND_W-1:0]  r_fifo_cnt;

    logic [LEN_W-1:0]   eff_len;
    logic [FILL_W-1:0]  fill_eff;
    logic               fill_full;
    logic               tick_ok;
    logic               load_ok;
    logic [RING_AW-1:0] rd_addr;
    logic               hazard;
    logic               in_accept;
    logic               out_accept;
    t_s1                n_s1;
    logic [FILL_W-1:0]  n_fill;
    logic [COUNT_W-1:0] n_ticks;
    logic signed [SAMPLE_W-1:0] n_front;
    logic signed [SAMPLE_W:0]   sum;
    logic signed [SAMPLE_W:0]   sum_adj;
    logic signed [PROD_W-1:0]   prod_adj;
    logic signed [SAMPLE_W-1:0] wr_data;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_ring_length < RING_LENGTH_MIN) begin
            eff_len = RING_LENGTH_MIN;
        end else if (r_ring_length > RING_LENGTH_MAX) begin
            eff_len = RING_LENGTH_MAX;
        end else begin
            eff_len = r_ring_length;
        end
    end

    // restart empties the ring only for loads
    assign fill_eff  = (i_in_item.command == CMD_LOAD && i_in_item.restart) ? '0 : r_fill;
    assign fill_full = fill_eff >= FILL_W'(eff_len);
    assign tick_ok   = (i_in_item.command == CMD_TICK) && fill_full;
    assign load_ok   = (i_in_item.command == CMD_LOAD) && !fill_full;
    assign rd_addr   = r_head + RING_AW'(1);

    // a tick must not read a slot that an item in flight still has to write
    assign hazard = tick_ok && (
        (r_s1.valid && (r_s1.tick_ok || r_s1.load_ok) && r_s1.wr_addr == rd_addr) ||
        (r_s2.valid && r_s2.wr_en && r_s2.wr_addr == rd_addr) ||
        (r_s3.valid && r_s3.wr_en && r_s3.wr_addr == rd_addr));

    assign o_in_stall = (r_pending >= PEND_W'(FIFO_DEPTH)) || (i_in_valid && hazard);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = o_out_valid && !i_out_stall;

    always_comb begin
        n_fill  = fill_eff;
        n_ticks = r_ticks;
        if (load_ok) begin
            n_fill = fill_eff + FILL_W'(1);
        end
        if (tick_ok) begin
            n_ticks = r_ticks + COUNT_W'(1);
        end
        n_s1.valid      = 1'b1;
        n_s1.tick_ok    = tick_ok;
        n_s1.load_ok    = load_ok;
        n_s1.load_empty = (fill_eff == '0);
        n_s1.fill_nz    = (n_fill != '0);
        n_s1.load_value = i_in_item.load_value;
        n_s1.wr_addr    = r_head + fill_eff[RING_AW-1:0];
        n_s1.ring_full  = n_fill >= FILL_W'(eff_len);
        n_s1.tick_count = n_ticks;
        if (i_in_item.command == CMD_TICK) begin
            n_s1.status = tick_ok ? ST_OK : ST_NOT_FULL;
        end else begin
            n_s1.status = load_ok ? ST_OK : ST_FULL;
        end
    end

    // configuration and ring control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_length <= RING_LENGTH_RESET;
            r_decay_gain  <= DECAY_GAIN_RESET;
            r_head        <= '0;
            r_fill        <= '0;
            r_ticks       <= '0;
            r_pending     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RING_LENGTH: r_ring_length <= i_cfg_data[LEN_W-1:0];
                    CFG_DECAY_GAIN:  r_decay_gain  <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_fill  <= n_fill;
                r_ticks <= n_ticks;
                if (tick_ok) begin
                    r_head <= rd_addr;
                end
            end
            case ({in_accept, out_accept})
                2'b10:   r_pending <= r_pending + PEND_W'(1);
                2'b01:   r_pending <= r_pending - PEND_W'(1);
                default: r_pending <= r_pending;
            endcase
        end
    end

    // ring memory: one read, one write port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_ring[rd_addr];
        if (r_s3.valid && r_s3.wr_en) begin
            r_ring[r_s3.wr_addr] <= wr_data;
        end
    end

    // stage 1: sample read back, average toward zero, new front
    assign sum     = {r_front[SAMPLE_W-1], r_front} + {r_rd_data[SAMPLE_W-1], r_rd_data};
    assign sum_adj = sum + {{SAMPLE_W{1'b0}}, sum[SAMPLE_W]};

    always_comb begin
        n_front = r_front;
        if (r_s1.tick_ok) begin
            n_front = r_rd_data;
        end else if (r_s1.load_ok && r_s1.load_empty) begin
            n_front = r_s1.load_value;
        end
    end

    // stage 3: scaled value truncated toward zero
    assign prod_adj = r_s3_prod + (r_s3_prod[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    assign wr_data  = r_s3.tick_ok ? prod_adj[SAMPLE_W+15:16] : r_s3.load_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else begin
            r_s1.valid <= in_accept;
            r_s2.valid <= r_s1.valid;
            r_s3.valid <= r_s2.valid;
        end
        if (in_accept) begin
            r_s1.tick_ok    <= n_s1.tick_ok;
            r_s1.load_ok    <= n_s1.load_ok;
            r_s1.load_empty <= n_s1.load_empty;
            r_s1.fill_nz    <= n_s1.fill_nz;
            r_s1.load_value <= n_s1.load_value;
            r_s1.wr_addr    <= n_s1.wr_addr;
            r_s1.status     <= n_s1.status;
            r_s1.ring_full  <= n_s1.ring_full;
            r_s1.tick_count <= n_s1.tick_count;
        end
        if (r_s1.valid) begin
            r_front                     <= n_front;
            r_s2_avg                    <= sum_adj[SAMPLE_W:1];
            r_s2.tick_ok                <= r_s1.tick_ok;
            r_s2.wr_en                  <= r_s1.tick_ok || r_s1.load_ok;
            r_s2.wr_addr                <= r_s1.wr_addr;
            r_s2.load_value             <= r_s1.load_value;
            r_s2.result.current_sample  <= r_s1.fill_nz ? n_front : '0;
            r_s2.result.status          <= r_s1.status;
            r_s2.result.ring_full       <= r_s1.ring_full;
            r_s2.result.tick_count      <= r_s1.tick_count;
        end
        if (r_s2.valid) begin
            r_s3.tick_ok    <= r_s2.tick_ok;
            r_s3.wr_en      <= r_s2.wr_en;
            r_s3.wr_addr    <= r_s2.wr_addr;
            r_s3.load_value <= r_s2.load_value;
            r_s3.result     <= r_s2.result;
            r_s3_prod       <= PROD_W'(r_s2_avg) * PROD_W'($signed({1'b0, r_decay_gain}));
        end
    end

    // output queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (r_s3.valid) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (out_accept) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({r_s3.valid, out_accept})
                2'b10:   r_fifo_cnt <= r_fifo_cnt + PEND_W'(1);
                2'b01:   r_fifo_cnt <= r_fifo_cnt - PEND_W'(1);
                default: r_fifo_cnt <= r_fifo_cnt;
            endcase
        end
        if (r_s3.valid) begin
            r_fifo[r_wr_ptr] <= r_s3.result;
        end
    end

    assign o_out_valid = (r_fifo_cnt != '0);
    assign o_out_item  = r_fifo[r_rd_ptr];

    // credit count covers every item in the pipeline and the queue
    a_pending_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == PEND_W'(r_s1.valid) + PEND_W'(r_s2.valid) + PEND_W'(r_s3.valid)
                     + r_fifo_cnt)
        else $error("pending count out of step with pipeline and queue");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAX_RING))
        else $error("fill count beyond ring size");

    a_ticks_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_accept && tick_ok) |=> $stable(r_ticks))
        else $error("tick count moved without an accepted tick");

    a_tick_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && tick_ok |=> !(r_s2.valid && r_s2.wr_en && r_s2.wr_addr == $past(rd_addr)))
        else $error("tick read a slot with a write still in flight");

endmodule
